FILE: design/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Constants, types and helper functions shared by the subtractive random
// generator modules.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned TABLE_LEN = 55;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned VAL_W     = 30;
  localparam int unsigned SEED_W    = 28;

  localparam logic [VAL_W-1:0]  MODULUS     = 30'd1000000000;
  localparam logic [SEED_W-1:0] SEED_BASE   = 28'd161803398;
  localparam logic [IDX_W-1:0]  LAST_POS    = 6'd55;
  localparam logic [IDX_W-1:0]  LAG_START   = 6'd31;
  localparam logic [IDX_W-1:0]  FILL_STRIDE = 6'd21;
  localparam logic [IDX_W-1:0]  FILL_STEPS  = 6'd54;
  localparam logic [IDX_W-1:0]  LAG_SPLIT   = 6'd24;
  localparam logic [1:0]        LAST_PASS   = 2'd3;

  // Command codes carried in the func field.
  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_WARM_RD,
    ST_WARM_WR,
    ST_DRAW_RD,
    ST_DRAW_WR
  } srg_state_t;

  // Table port request: a write and two read addresses.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } tbl_req_t;

  typedef struct packed {
    logic             load;
    logic [VAL_W-1:0] value;
    logic             seeded;
  } result_t;

  // a - b modulo 10^9 for operands already reduced.
  function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      diff = diff + {1'b0, MODULUS};
    end
    return diff[VAL_W-1:0];
  endfunction

  // Cyclic step over positions 1..55; anything at or past 55 wraps to 1.
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
    return (idx >= LAST_POS) ? IDX_W'(1) : idx + IDX_W'(1);
  endfunction

  // Position 31 places ahead of i, cyclic over 1..55.
  function automatic logic [IDX_W-1:0] partner(input logic [IDX_W-1:0] i);
    return (i <= LAG_SPLIT) ? i + LAG_START : i - LAG_SPLIT;
  endfunction

endpackage

FILE: design/srg_if.sv
// ----------------------------------------------------------------------------
// srg_if
// Valid/ready channels for draw commands and generated values.
// ----------------------------------------------------------------------------
interface srg_cmd_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [27:0] seed_magnitude;

  modport source (output valid, output func, output seed_magnitude, input ready);
  modport sink (input valid, input func, input seed_magnitude, output ready);
endinterface

interface srg_rsp_if;
  logic        valid;
  logic        ready;
  logic [29:0] value;
  logic        seeded;

  modport source (output valid, output value, output seeded, input ready);
  modport sink (input valid, input value, input seeded, output ready);
endinterface

FILE: design/srg_table_ram.sv
// ----------------------------------------------------------------------------
// srg_table_ram
// The 55-word lag table: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module srg_table_ram (
  input  logic                           clk,
  input  srg_pkg::tbl_req_t              req,
  output logic [srg_pkg::VAL_W-1:0]      rd_a,
  output logic [srg_pkg::VAL_W-1:0]      rd_b
);
  import srg_pkg::*;

  logic [VAL_W-1:0] mem [TABLE_LEN];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

FILE: design/srg_ctrl.sv
// ----------------------------------------------------------------------------
// srg_ctrl
// Sequencer for seeding, warm-up and draws over the lag table.
// ----------------------------------------------------------------------------
module srg_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  srg_cmd_if.sink                        cmd,
  input  logic                           out_free,
  input  logic [srg_pkg::VAL_W-1:0]      rd_a,
  input  logic [srg_pkg::VAL_W-1:0]      rd_b,
  output srg_pkg::tbl_req_t              tbl_req,
  output srg_pkg::result_t               result
);
  import srg_pkg::*;

  srg_state_t       state, state_next;
  logic [VAL_W-1:0] cur, cur_next;
  logic [VAL_W-1:0] prev, prev_next;
  logic [IDX_W-1:0] step, step_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [1:0]       pass, pass_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [IDX_W-1:0] lag_index, lag_index_next;
  logic             initialized, initialized_next;
  logic             seeded_item, seeded_item_next;

  logic             need_seed;
  logic [SEED_W-1:0] seed_start;
  logic [IDX_W:0]   pos_sum;
  logic [IDX_W-1:0] ri_adv;
  logic [IDX_W-1:0] li_adv;
  logic [VAL_W-1:0] diff;

  assign need_seed  = (cmd.func == FUNC_RESEED) || !initialized;
  assign seed_start = (cmd.seed_magnitude > SEED_BASE) ? '0 : SEED_BASE - cmd.seed_magnitude;
  assign pos_sum    = {1'b0, pos} + {1'b0, FILL_STRIDE};
  assign ri_adv     = advance(read_index);
  assign li_adv     = advance(lag_index);
  assign diff       = sub_mod(rd_a, rd_b);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = need_seed ? ST_FILL : ST_DRAW_WR;
        end
      end
      ST_FILL: begin
        if (step == FILL_STEPS) begin
          state_next = ST_WARM_RD;
        end
      end
      ST_WARM_RD: state_next = ST_WARM_WR;
      ST_WARM_WR: begin
        state_next = (step == LAST_POS && pass == LAST_PASS) ? ST_DRAW_RD : ST_WARM_RD;
      end
      ST_DRAW_RD: state_next = ST_DRAW_WR;
      ST_DRAW_WR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready        = 1'b0;
    tbl_req          = '0;
    result.load      = 1'b0;
    result.value     = diff;
    result.seeded    = seeded_item;
    cur_next         = cur;
    prev_next        = prev;
    step_next        = step;
    pos_next         = pos;
    pass_next        = pass;
    read_index_next  = read_index;
    lag_index_next   = lag_index;
    initialized_next = initialized;
    seeded_item_next = seeded_item;
    unique case (state)
      ST_IDLE: begin
        cmd.ready       = 1'b1;
        tbl_req.raddr_a = ri_adv - IDX_W'(1);
        tbl_req.raddr_b = li_adv - IDX_W'(1);
        if (cmd.valid) begin
          seeded_item_next = need_seed;
          if (need_seed) begin
            // The top position takes the start value before the scatter fill.
            tbl_req.we    = 1'b1;
            tbl_req.waddr = LAST_POS - IDX_W'(1);
            tbl_req.wdata = VAL_W'(seed_start);
            cur_next      = VAL_W'(seed_start);
            prev_next     = VAL_W'(1);
            step_next     = IDX_W'(1);
            pos_next      = FILL_STRIDE;
          end else begin
            read_index_next = ri_adv;
            lag_index_next  = li_adv;
          end
        end
      end
      ST_FILL: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = pos - IDX_W'(1);
        tbl_req.wdata = prev;
        prev_next     = sub_mod(cur, prev);
        cur_next      = prev;
        pos_next      = (pos_sum >= (IDX_W+1)'(TABLE_LEN)) ?
                        IDX_W'(pos_sum - (IDX_W+1)'(TABLE_LEN)) : pos_sum[IDX_W-1:0];
        if (step == FILL_STEPS) begin
          step_next = IDX_W'(1);
          pass_next = '0;
        end else begin
          step_next = step + IDX_W'(1);
        end
      end
      ST_WARM_RD: begin
        tbl_req.raddr_a = step - IDX_W'(1);
        tbl_req.raddr_b = partner(step) - IDX_W'(1);
      end
      ST_WARM_WR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = step - IDX_W'(1);
        tbl_req.wdata = diff;
        if (step == LAST_POS) begin
          step_next = IDX_W'(1);
          pass_next = pass + 2'd1;
          if (pass == LAST_PASS) begin
            read_index_next  = '0;
            lag_index_next   = LAG_START;
            initialized_next = 1'b1;
          end
        end else begin
          step_next = step + IDX_W'(1);
        end
      end
      ST_DRAW_RD: begin
        tbl_req.raddr_a = ri_adv - IDX_W'(1);
        tbl_req.raddr_b = li_adv - IDX_W'(1);
        read_index_next = ri_adv;
        lag_index_next  = li_adv;
      end
      ST_DRAW_WR: begin
        // Keep the same read addresses so the words hold while the output stalls.
        tbl_req.raddr_a = read_index - IDX_W'(1);
        tbl_req.raddr_b = lag_index - IDX_W'(1);
        if (out_free) begin
          tbl_req.we    = 1'b1;
          tbl_req.waddr = read_index - IDX_W'(1);
          tbl_req.wdata = diff;
          result.load   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      read_index  <= '0;
      lag_index   <= '0;
      initialized <= 1'b0;
      step        <= '0;
      pass        <= '0;
    end else begin
      state       <= state_next;
      read_index  <= read_index_next;
      lag_index   <= lag_index_next;
      initialized <= initialized_next;
      step        <= step_next;
      pass        <= pass_next;
    end
    cur         <= cur_next;
    prev        <= prev_next;
    pos         <= pos_next;
    seeded_item <= seeded_item_next;
  end

endmodule

FILE: design/subtractive_random_generator.sv
// Draw: the command beat is accepted in ST_IDLE with the table read, then ST_DRAW_WR
// writes back the new word and loads the result register, waiting while it is full; a
// new command is taken only back in ST_IDLE. A command that seeds makes 54 fill writes
// and 4 x 55 warm-up steps, one table read and write per step, before its draw.
// Synchronous reset clears the sequencer, indices and seeded flag; the table is not
// cleared, and the first command after reset always seeds it.
// ----------------------------------------------------------------------------
// subtractive_random_generator
// Lagged subtractive random number generator over a 55-word table modulo 10^9.
// ----------------------------------------------------------------------------
module subtractive_random_generator (
  input  logic     clk,
  input  logic     rst,
  srg_cmd_if.sink  cmd,
  srg_rsp_if.source rsp
);
  import srg_pkg::*;

  tbl_req_t         tbl_req;
  result_t          result;
  logic [VAL_W-1:0] rd_a;
  logic [VAL_W-1:0] rd_b;
  logic             out_free;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !rsp.valid || rsp.ready;

  srg_table_ram u_table (
    .clk  (clk),
    .req  (tbl_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  srg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .out_free (out_free),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .tbl_req  (tbl_req),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (result.load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (result.load) begin
      rsp.value  <= result.value;
      rsp.seeded <= result.seeded;
    end
  end

endmodule
